// ----- sv/mted_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mted_pkg
// Shared widths, register codes, reset values, command and status types and
// the reciprocal table of the multi-tap echo delay.
// ----------------------------------------------------------------------------
package mted_pkg;

   localparam int HISTORY_FRAMES_DEF = 8192;
   localparam int MAX_ECHOES_DEF     = 8;
   localparam int MAX_CHANNELS_DEF   = 2;

   localparam int SAMPLE_W    = 16;
   localparam int DELAY_W     = 13;
   localparam int COUNT_W     = 4;
   localparam int CHAN_CFG_W  = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int ACC_W       = 20;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_FRAMES       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_COUNT         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALTERNATE_POLARITY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINEAR_DIVISOR     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT      = 3'd4;

   localparam logic [DELAY_W-1:0]    RST_DELAY_FRAMES  = 13'd1000;
   localparam logic [COUNT_W-1:0]    RST_ECHO_COUNT    = 4'd1;
   localparam logic                  RST_ALTERNATE     = 1'b0;
   localparam logic                  RST_LINEAR        = 1'b0;
   localparam logic [CHAN_CFG_W-1:0] RST_CHANNEL_COUNT = 2'd2;

   typedef struct packed {
      logic [DELAY_W-1:0]    delay_frames;
      logic [COUNT_W-1:0]    echo_count;
      logic                  alternate_polarity;
      logic                  linear_divisor;
      logic [CHAN_CFG_W-1:0] channel_count;
   } cfg_type;

   typedef struct packed {
      logic clear_wr;
      logic start;
      logic red_step;
      logic tap_issue;
      logic tap_mul;
      logic tap_acc;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic red_skip;
      logic red_last;
      logic taps_done;
      logic rsp_free;
   } status_type;

   // Entry i holds floor(2^20 / (i + 2)), the reciprocal of divisor i + 2.
   localparam logic [RECIP_W-1:0] RECIP_LIN [16] = '{
      RECIP_W'((1 << RECIP_SHIFT) / 2),  RECIP_W'((1 << RECIP_SHIFT) / 3),
      RECIP_W'((1 << RECIP_SHIFT) / 4),  RECIP_W'((1 << RECIP_SHIFT) / 5),
      RECIP_W'((1 << RECIP_SHIFT) / 6),  RECIP_W'((1 << RECIP_SHIFT) / 7),
      RECIP_W'((1 << RECIP_SHIFT) / 8),  RECIP_W'((1 << RECIP_SHIFT) / 9),
      RECIP_W'((1 << RECIP_SHIFT) / 10), RECIP_W'((1 << RECIP_SHIFT) / 11),
      RECIP_W'((1 << RECIP_SHIFT) / 12), RECIP_W'((1 << RECIP_SHIFT) / 13),
      RECIP_W'((1 << RECIP_SHIFT) / 14), RECIP_W'((1 << RECIP_SHIFT) / 15),
      RECIP_W'((1 << RECIP_SHIFT) / 16), RECIP_W'((1 << RECIP_SHIFT) / 17)
   };

   // Number of shifted ring sizes that do not exceed the largest delay value.
   function automatic int reduce_steps(int hf);
      int n;
      n = 0;
      for (int j = 0; j < 16; j++) begin
         if ((hf << j) <= ((1 << DELAY_W) - 1)) begin
            n = j + 1;
         end
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ----- sv/mted_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mted_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module mted_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/mted_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mted_ctrl
// Sequencer of the echo delay: clearing pass, delay reduction, three steps
// per tap and the result hand-off.
// ----------------------------------------------------------------------------
module mted_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mted_pkg::status_type status,
   output mted_pkg::cmd_type    cmd
);
   import mted_pkg::*;

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_REDUCE   = 3'd2;
   localparam logic [2:0] ST_TAP_ADDR = 3'd3;
   localparam logic [2:0] ST_TAP_MUL  = 3'd4;
   localparam logic [2:0] ST_TAP_ACC  = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = status.red_skip ? ST_TAP_ADDR : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (status.red_last) begin
               state_in = ST_TAP_ADDR;
            end
         end
         ST_TAP_ADDR: begin
            cmd.tap_issue = 1'b1;
            state_in      = ST_TAP_MUL;
         end
         ST_TAP_MUL: begin
            cmd.tap_mul = 1'b1;
            state_in    = ST_TAP_ACC;
         end
         ST_TAP_ACC: begin
            cmd.tap_acc = 1'b1;
            state_in    = status.taps_done ? ST_FINISH : ST_TAP_ADDR;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ----- sv/mted_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mted_dp
// Datapath of the echo delay: ring pointers, history addressing, delay
// reduction, reciprocal divider, accumulator and output register.
// ----------------------------------------------------------------------------
module mted_dp #(
   parameter int HISTORY_FRAMES = mted_pkg::HISTORY_FRAMES_DEF,
   parameter int MAX_ECHOES     = mted_pkg::MAX_ECHOES_DEF,
   parameter int MAX_CHANNELS   = mted_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  mted_pkg::cfg_type                           cfg,
   input  mted_pkg::cmd_type                           cmd,
   output mted_pkg::status_type                        status,
   input  logic signed [mted_pkg::SAMPLE_W-1:0]        req_in_sample,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [mted_pkg::SAMPLE_W-1:0]        rsp_out_sample,
   output logic                                        ram_wr_en,
   output logic [$clog2(HISTORY_FRAMES*MAX_CHANNELS)-1:0] ram_wr_addr,
   output logic [mted_pkg::SAMPLE_W-1:0]               ram_wr_data,
   output logic                                        ram_rd_en,
   output logic [$clog2(HISTORY_FRAMES*MAX_CHANNELS)-1:0] ram_rd_addr,
   input  logic [mted_pkg::SAMPLE_W-1:0]               ram_rd_data
);
   import mted_pkg::*;

   localparam int FW        = $clog2(HISTORY_FRAMES);
   localparam int CW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DEPTH     = HISTORY_FRAMES * MAX_CHANNELS;
   localparam int AW        = $clog2(DEPTH);
   localparam int SW        = ((FW > DELAY_W) ? FW : DELAY_W) + 1;
   localparam int RED_STEPS = reduce_steps(HISTORY_FRAMES);
   localparam int RED_W     = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
   localparam int PROD_W    = SAMPLE_W + RECIP_W;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

   function automatic logic [AW-1:0] row_addr(logic [FW-1:0] f, logic [CW-1:0] c);
      return AW'(f) * AW'(MAX_CHANNELS) + AW'(c);
   endfunction

   logic [AW-1:0]              clr_ff, clr_in;
   logic [FW-1:0]              fp_ff, fp_in;
   logic [CW-1:0]              chpos_ff, chpos_in;
   logic [CW-1:0]              ch_ff;
   logic [FW-1:0]              tf_ff;
   logic [DELAY_W-1:0]         red_ff;
   logic [RED_W-1:0]           red_cnt_ff;
   logic [COUNT_W-1:0]         k_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [SAMPLE_W-1:0]        mag_ff;
   logic                       neg_ff;
   logic [SAMPLE_W-1:0]        d_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   logic [3:0]                 chans;
   logic [COUNT_W-1:0]         taps;
   logic [CW-1:0]              ch_cur;
   logic [SW-1:0]              tf_diff, tf_wrap;
   logic [FW-1:0]              tf_next;
   logic [31:0]                red_sub;
   logic [DELAY_W-1:0]         red_next;
   logic                       tap_neg;
   logic [SAMPLE_W-1:0]        tap_mag;
   logic [SAMPLE_W-1:0]        divisor;
   logic [RECIP_W-1:0]         recip;
   logic [SAMPLE_W-1:0]        q0, q;
   logic [31:0]                qd, rem;
   logic signed [ACC_W-1:0]    tap_term;
   logic signed [ACC_W-1:0]    acc_round, acc_half;
   logic signed [SAMPLE_W-1:0] sat_value;
   logic [3:0]                 next_ch;
   logic                       rsp_free;

   always_comb begin
      if (cfg.channel_count == '0) begin
         chans = 4'd1;
      end else if (4'(cfg.channel_count) > 4'(MAX_CHANNELS)) begin
         chans = 4'(MAX_CHANNELS);
      end else begin
         chans = 4'(cfg.channel_count);
      end
      if (cfg.echo_count == '0) begin
         taps = COUNT_W'(1);
      end else if (cfg.echo_count > COUNT_W'(MAX_ECHOES)) begin
         taps = COUNT_W'(MAX_ECHOES);
      end else begin
         taps = cfg.echo_count;
      end
      ch_cur = (4'(chpos_ff) >= chans) ? '0 : chpos_ff;
   end

   // Tap frames walk backward by the reduced delay and wrap around the ring.
   always_comb begin
      tf_diff = SW'(tf_ff) - SW'(red_ff);
      tf_wrap = tf_diff + SW'(HISTORY_FRAMES);
      tf_next = tf_diff[SW-1] ? tf_wrap[FW-1:0] : tf_diff[FW-1:0];
      red_sub = 32'(HISTORY_FRAMES) << red_cnt_ff;
      red_next = (32'(red_ff) >= red_sub) ? (red_ff - red_sub[DELAY_W-1:0]) : red_ff;
   end

   always_comb begin
      tap_neg = ram_rd_data[SAMPLE_W-1];
      tap_mag = tap_neg ? (~ram_rd_data + SAMPLE_W'(1)) : ram_rd_data;
      if (cfg.linear_divisor) begin
         divisor = SAMPLE_W'(k_ff) + SAMPLE_W'(1);
         recip   = RECIP_LIN[k_ff - COUNT_W'(1)];
      end else begin
         divisor = SAMPLE_W'(1) << k_ff;
         recip   = (RECIP_W'(1) << (RECIP_W - 1)) >> (k_ff - COUNT_W'(1));
      end
   end

   // The reciprocal estimate is at most one below the true quotient.
   always_comb begin
      q0       = prod_ff[PROD_W-1:RECIP_SHIFT];
      qd       = 32'(q0) * 32'(d_ff);
      rem      = 32'(mag_ff) - qd;
      q        = (rem >= 32'(d_ff)) ? (q0 + SAMPLE_W'(1)) : q0;
      tap_term = neg_ff ? (ACC_W'(0) - $signed(ACC_W'(q))) : $signed(ACC_W'(q));
   end

   always_comb begin
      acc_round = acc_ff + $signed(ACC_W'(acc_ff[ACC_W-1]));
      acc_half  = acc_round >>> 1;
      if (acc_half > SAT_HI) begin
         sat_value = SAT_HI[SAMPLE_W-1:0];
      end else if (acc_half < SAT_LO) begin
         sat_value = SAT_LO[SAMPLE_W-1:0];
      end else begin
         sat_value = acc_half[SAMPLE_W-1:0];
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      clr_in       = clr_ff;
      fp_in        = fp_ff;
      chpos_in     = chpos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      next_ch      = 4'(ch_ff) + 4'd1;
      if (cmd.clear_wr) begin
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (next_ch >= chans) begin
            chpos_in = '0;
            fp_in    = (fp_ff == FW'(HISTORY_FRAMES - 1)) ? '0 : (fp_ff + FW'(1));
         end else begin
            chpos_in = next_ch[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         fp_ff        <= '0;
         chpos_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         fp_ff        <= fp_in;
         chpos_ff     <= chpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ch_ff      <= ch_cur;
         tf_ff      <= fp_ff;
         red_ff     <= cfg.delay_frames;
         red_cnt_ff <= RED_W'((RED_STEPS > 0) ? (RED_STEPS - 1) : 0);
         k_ff       <= COUNT_W'(1);
         acc_ff     <= ACC_W'(req_in_sample);
      end
      if (cmd.red_step) begin
         red_ff     <= red_next;
         red_cnt_ff <= red_cnt_ff - RED_W'(1);
      end
      if (cmd.tap_issue) begin
         tf_ff <= tf_next;
      end
      if (cmd.tap_mul) begin
         mag_ff  <= tap_mag;
         neg_ff  <= tap_neg ^ (cfg.alternate_polarity & k_ff[0]);
         d_ff    <= divisor;
         prod_ff <= PROD_W'(tap_mag) * PROD_W'(recip);
      end
      if (cmd.tap_acc) begin
         acc_ff <= acc_ff + tap_term;
         k_ff   <= k_ff + COUNT_W'(1);
      end
      if (cmd.finish) begin
         rsp_data_ff <= sat_value;
      end
   end

   assign ram_wr_en   = cmd.clear_wr | cmd.start;
   assign ram_wr_addr = cmd.clear_wr ? clr_ff : row_addr(fp_ff, ch_cur);
   assign ram_wr_data = cmd.clear_wr ? '0 : req_in_sample;
   assign ram_rd_en   = cmd.tap_issue;
   assign ram_rd_addr = row_addr(tf_next, ch_ff);

   always_comb begin
      status.clear_last = (clr_ff == AW'(DEPTH - 1));
      status.red_skip   = (RED_STEPS == 0);
      status.red_last   = (red_cnt_ff == '0);
      status.taps_done  = (k_ff == taps);
      status.rsp_free   = rsp_free;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_data_ff;

endmodule
`default_nettype wire

// ----- sv/multi_tap_echo_delay_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_tap_echo_delay_top
// Multi-tap feed-forward echo over an interleaved 16-bit PCM stream.
// ----------------------------------------------------------------------------
// Samples enter on the req_ channel one beat at a time, channels interleaved
// in frame order, and each beat yields one echoed sample on the rsp_ channel.
// A beat is taken when valid is high and stall is low.
// The user must write registers through the csr_ port only while no sample
// is in flight; the block itself does not enforce this. After reset the
// history memory is cleared, one entry a cycle, over all HISTORY_FRAMES *
// MAX_CHANNELS entries (16384 by default); req_stall stays high during that
// pass while register writes are taken as usual. Each sample runs the delay
// reduction, one step per ring size shifted below 8192 (none for an 8192-frame
// ring), then three steps per effective tap: the history read, the reciprocal
// multiply and the corrected accumulate; a finish step then loads the result
// into the output register. The next sample is taken while a result still
// waits; if the receiver stalls, the finished result is held and the
// following sample waits in its last step until the output register frees.
// ----------------------------------------------------------------------------
module multi_tap_echo_delay_top #(
   parameter int HISTORY_FRAMES = mted_pkg::HISTORY_FRAMES_DEF,
   parameter int MAX_ECHOES     = mted_pkg::MAX_ECHOES_DEF,
   parameter int MAX_CHANNELS   = mted_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [mted_pkg::SAMPLE_W-1:0]   req_in_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mted_pkg::SAMPLE_W-1:0]   rsp_out_sample,
   input  logic                                   csr_write_enable,
   input  logic [mted_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mted_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import mted_pkg::*;

   localparam int DEPTH = HISTORY_FRAMES * MAX_CHANNELS;
   localparam int AW    = $clog2(DEPTH);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   cmd_type    cmd;
   status_type status;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [SAMPLE_W-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DELAY_FRAMES:       cfg_in.delay_frames       = csr_write_data[DELAY_W-1:0];
            CSR_ECHO_COUNT:         cfg_in.echo_count         = csr_write_data[COUNT_W-1:0];
            CSR_ALTERNATE_POLARITY: cfg_in.alternate_polarity = csr_write_data[0];
            CSR_LINEAR_DIVISOR:     cfg_in.linear_divisor     = csr_write_data[0];
            CSR_CHANNEL_COUNT:      cfg_in.channel_count      = csr_write_data[CHAN_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_frames       <= RST_DELAY_FRAMES;
         cfg_ff.echo_count         <= RST_ECHO_COUNT;
         cfg_ff.alternate_polarity <= RST_ALTERNATE;
         cfg_ff.linear_divisor     <= RST_LINEAR;
         cfg_ff.channel_count      <= RST_CHANNEL_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mted_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mted_dp #(
      .HISTORY_FRAMES (HISTORY_FRAMES),
      .MAX_ECHOES     (MAX_ECHOES),
      .MAX_CHANNELS   (MAX_CHANNELS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .status         (status),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   mted_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTH
   // The clearing pass holds off input right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input not held off during history clearing");

   // Only one sample is in flight at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block accepted a beat while still processing");

   // A new result only appears at the end of a sample's processing.
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a sample in flight");
`endif

endmodule
`default_nettype wire
